// ===== design/cpra_pkg.sv =====
package cpra_pkg;

    localparam int REG_SLOTS       = 64;
    localparam int IDX_W           = $clog2(REG_SLOTS);
    localparam int OWNER_FIELD_W   = 16;
    localparam int OWNER_WIDTH_DEF = 16;
    localparam int INT_COUNT       = 15;
    localparam int FLT_COUNT       = 21;

    localparam logic [1:0] CLS_INT = 2'd0;
    localparam logic [1:0] CLS_FLT = 2'd1;
    localparam logic [1:0] CLS_PTR = 2'd2;

    localparam logic [3:0] SPILL_BYTES_WORD = 4'd4;
    localparam logic [3:0] SPILL_BYTES_PTR  = 4'd8;

    // s1, s2..s11, t3..t6
    localparam logic [IDX_W-1:0] INT_PREFS [INT_COUNT] = '{
        6'd9,  6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31
    };

    // ft0..ft7, fs3..fs11, ft8..ft11
    localparam logic [IDX_W-1:0] FLT_PREFS [FLT_COUNT] = '{
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
        6'd51, 6'd52, 6'd53, 6'd54, 6'd55, 6'd56, 6'd57, 6'd58, 6'd59,
        6'd60, 6'd61, 6'd62, 6'd63
    };

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [1:0]               reg_class;
        logic [OWNER_FIELD_W-1:0] owner_id;
    } req_item_t;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] reg_number;
        logic             spilled;
        logic [3:0]       spill_bytes;
    } rsp_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] reg_number;
    } pick_t;

    typedef struct packed {
        logic             alloc_en;
        logic [IDX_W-1:0] alloc_idx;
        logic             release_en;
    } tbl_ctrl_t;

endpackage

// ===== design/cpra_pick.sv =====
module cpra_pick (
    input  logic [cpra_pkg::REG_SLOTS-1:0] busy_vec,
    input  logic [1:0]                     reg_class,
    output cpra_pkg::pick_t                pick
);
    import cpra_pkg::*;

    always_comb
    begin
        pick = '0;
        if (reg_class == CLS_FLT)
        begin
            for (int k = FLT_COUNT - 1; k >= 0; k--)
            begin
                if (!busy_vec[FLT_PREFS[k]])
                begin
                    pick.found      = 1'b1;
                    pick.reg_number = FLT_PREFS[k];
                end
            end
        end
        else
        begin
            for (int k = INT_COUNT - 1; k >= 0; k--)
            begin
                if (!busy_vec[INT_PREFS[k]])
                begin
                    pick.found      = 1'b1;
                    pick.reg_number = INT_PREFS[k];
                end
            end
        end
    end

endmodule

// ===== design/cpra_table.sv =====
module cpra_table #(
    parameter int OWNER_WIDTH = cpra_pkg::OWNER_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cpra_pkg::tbl_ctrl_t            ctrl,
    input  logic [OWNER_WIDTH-1:0]         tag,
    output logic [cpra_pkg::REG_SLOTS-1:0] busy_vec
);
    import cpra_pkg::*;

    logic [REG_SLOTS-1:0]   busy_reg;
    logic [REG_SLOTS-1:0]   busy_next;
    logic [OWNER_WIDTH-1:0] tag_reg [REG_SLOTS];

    always_comb
    begin
        busy_next = busy_reg;
        for (int i = 0; i < REG_SLOTS; i++)
        begin
            if (ctrl.release_en && tag_reg[i] == tag)
                busy_next[i] = 1'b0;
            if (ctrl.alloc_en && ctrl.alloc_idx == IDX_W'(i))
                busy_next[i] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= '0;
        else
            busy_reg <= busy_next;
    end

    // tags are only looked at while the entry is busy
    always_ff @(posedge clk)
    begin
        if (ctrl.alloc_en)
            tag_reg[ctrl.alloc_idx] <= tag;
    end

    assign busy_vec = busy_reg;

endmodule

// ===== design/class_pool_register_allocator.sv =====
// Class-pool register allocator.
// Request channel: a transaction is taken on a rising edge with start high
// and busy low. busy is never raised, so a request may be issued every cycle.
// cmd alloc grants the first free register of the class list (integer and
// pointer share one list, float has its own, floats numbered 32 plus n) and
// tags it with owner_id; with no free register the result flags a spill with
// the slot length. cmd release frees every register tagged with owner_id.
// Result channel: every request gives exactly one result. done is high for
// one cycle per request, once the request has passed the input register and
// one pass of pick and tag compare into the result register; the result is
// valid while done is high and is taken at the edge that ends it. Throughput
// is one transaction per cycle; back-to-back requests see the table as left
// by the one before. The receiver cannot stall, so no result is held.
// Reset clears all busy bits and drops any transaction in flight.
module class_pool_register_allocator #(
    parameter int OWNER_WIDTH = cpra_pkg::OWNER_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cpra_pkg::req_item_t request,
    output logic                done,
    output cpra_pkg::rsp_item_t result
);
    import cpra_pkg::*;

    logic                 in_valid_reg;
    req_item_t            in_item_reg;
    logic                 done_reg;
    rsp_item_t            result_reg;
    rsp_item_t            result_next;
    logic [REG_SLOTS-1:0] busy_vec;
    pick_t                pick;
    tbl_ctrl_t            ctrl;
    logic [31:0]          owner_ext;
    logic [OWNER_WIDTH-1:0] tag;

    assign busy      = 1'b0;
    assign owner_ext = 32'(in_item_reg.owner_id);
    assign tag       = owner_ext[OWNER_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_item_reg <= request;
    end

    cpra_pick u_pick (
        .busy_vec  (busy_vec),
        .reg_class (in_item_reg.reg_class),
        .pick      (pick)
    );

    always_comb
    begin
        ctrl.alloc_en   = in_valid_reg && in_item_reg.cmd == CMD_ALLOC && pick.found;
        ctrl.alloc_idx  = pick.reg_number;
        ctrl.release_en = in_valid_reg && in_item_reg.cmd == CMD_RELEASE;
    end

    cpra_table #(
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .tag      (tag),
        .busy_vec (busy_vec)
    );

    always_comb
    begin
        result_next = '0;
        if (in_item_reg.cmd == CMD_ALLOC)
        begin
            if (pick.found)
            begin
                result_next.granted    = 1'b1;
                result_next.reg_number = pick.reg_number;
            end
            else
            begin
                result_next.spilled     = 1'b1;
                result_next.spill_bytes = (in_item_reg.reg_class == CLS_PTR) ?
                                          SPILL_BYTES_PTR : SPILL_BYTES_WORD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
